// ===== hw/rtl/object_bounding_box_core_defines.svh =====
// Assertion macros for the bounding box core.
// OBB_ASSERT_IMP: the consequent holds in the same cycle as the antecedent.
// OBB_ASSERT_NXT: the consequent holds in the cycle after the antecedent.
`ifndef OBJECT_BOUNDING_BOX_CORE_DEFINES_SVH
`define OBJECT_BOUNDING_BOX_CORE_DEFINES_SVH

`ifndef SYNTH
`define OBB_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("bounding box check failed");
`define OBB_ASSERT_NXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("bounding box check failed");
`else
`define OBB_ASSERT_IMP(label, clk, rst, ante, cons)
`define OBB_ASSERT_NXT(label, clk, rst, ante, cons)
`endif

`endif

// ===== hw/rtl/obb_pkg.sv =====
`default_nettype none

package obb_pkg;

  localparam int OBB_MAX_SIDE = 4096;
  localparam int FIELD_W      = 13;
  localparam int PIX_W        = 8;
  localparam int CFG_IDX_W    = 2;

  localparam logic [FIELD_W-1:0] FRAME_WIDTH_RST  = FIELD_W'(640);
  localparam logic [FIELD_W-1:0] FRAME_HEIGHT_RST = FIELD_W'(480);
  localparam logic [PIX_W-1:0]   OBJECT_COLOR_RST = '0;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FRAME_WIDTH  = 2'd0,
    REG_FRAME_HEIGHT = 2'd1,
    REG_OBJECT_COLOR = 2'd2
  } cfg_reg_t;

  // Frame geometry after clamping, and the object color.
  typedef struct packed {
    logic [FIELD_W-1:0] width;
    logic [FIELD_W-1:0] height;
    logic [PIX_W-1:0]   color;
  } cfg_t;

  typedef struct packed {
    logic signed [FIELD_W-1:0] top_row;
    logic [FIELD_W-1:0]        bottom_end;
    logic signed [FIELD_W-1:0] left_col;
    logic [FIELD_W-1:0]        right_end;
  } box_t;

  typedef struct packed {
    logic frame_end;
    box_t box;
  } track_status_t;

endpackage

`default_nettype wire

// ===== hw/rtl/obb_cfg.sv =====
`default_nettype none

module obb_cfg
  import obb_pkg::*;
#(
  parameter int MAX_SIDE = OBB_MAX_SIDE
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [FIELD_W-1:0]   cfg_data,
  output cfg_t                      cfg
);

  logic [FIELD_W-1:0] frame_width;
  logic [FIELD_W-1:0] frame_height;
  logic [PIX_W-1:0]   object_color;

  // Force a size into 1..MAX_SIDE; the result never exceeds the raw value
  // except for zero, so it still fits the field width.
  function automatic logic [FIELD_W-1:0] clamp_side(input logic [FIELD_W-1:0] raw);
    logic [FIELD_W-1:0] side;
    if (raw == '0) begin
      side = FIELD_W'(1);
    end else if (32'(raw) > 32'(MAX_SIDE)) begin
      side = FIELD_W'(MAX_SIDE);
    end else begin
      side = raw;
    end
    return side;
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= FRAME_WIDTH_RST;
      frame_height <= FRAME_HEIGHT_RST;
      object_color <= OBJECT_COLOR_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_FRAME_WIDTH:  frame_width  <= cfg_data;
        REG_FRAME_HEIGHT: frame_height <= cfg_data;
        REG_OBJECT_COLOR: object_color <= cfg_data[PIX_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    cfg.width  = clamp_side(frame_width);
    cfg.height = clamp_side(frame_height);
    cfg.color  = object_color;
  end

endmodule

`default_nettype wire

// ===== hw/rtl/obb_tracker.sv =====
`default_nettype none

module obb_tracker
  import obb_pkg::*;
#(
  parameter int MAX_SIDE = OBB_MAX_SIDE
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  cfg_t                  cfg,
  input  wire logic             step,
  input  wire logic [PIX_W-1:0] pix,
  output track_status_t         status
);

  localparam int CW   = (MAX_SIDE > 1) ? $clog2(MAX_SIDE) : 1;
  localparam int CMPW = (CW + 1 > FIELD_W) ? CW + 1 : FIELD_W;
  localparam logic [CW-1:0] MIN_COL_RST = CW'(MAX_SIDE - 1);

  logic [CW-1:0] col_count, col_count_next;
  logic [CW-1:0] row_count, row_count_next;
  logic [CW-1:0] min_row, min_row_next;
  logic [CW-1:0] max_row, max_row_next;
  logic [CW-1:0] min_col, min_col_next;
  logic [CW-1:0] max_col, max_col_next;
  logic          any_found, any_found_next;

  // Bounds with the current pixel folded in, before any end-of-frame clear.
  logic [CW-1:0] min_row_upd, max_row_upd, min_col_upd, max_col_upd;
  logic          any_found_upd;

  logic [CMPW-1:0] col_inc, row_inc;
  logic            row_end, frame_end, match;

  always_comb begin
    col_inc   = CMPW'(col_count) + CMPW'(1);
    row_inc   = CMPW'(row_count) + CMPW'(1);
    row_end   = col_inc >= CMPW'(cfg.width);
    frame_end = row_end && (row_inc >= CMPW'(cfg.height));
    match     = pix == cfg.color;
  end

  always_comb begin
    min_row_upd   = min_row;
    max_row_upd   = max_row;
    min_col_upd   = min_col;
    max_col_upd   = max_col;
    any_found_upd = any_found;
    if (match) begin
      if (!any_found) begin
        min_row_upd = row_count;
        min_col_upd = col_count;
        max_col_upd = col_count;
      end else begin
        if (col_count < min_col) begin
          min_col_upd = col_count;
        end
        if (col_count > max_col) begin
          max_col_upd = col_count;
        end
      end
      max_row_upd   = row_count;
      any_found_upd = 1'b1;
    end
  end

  always_comb begin
    min_row_next   = min_row_upd;
    max_row_next   = max_row_upd;
    min_col_next   = min_col_upd;
    max_col_next   = max_col_upd;
    any_found_next = any_found_upd;
    col_count_next = col_count;
    row_count_next = row_count;
    if (!row_end) begin
      col_count_next = col_count + CW'(1);
    end else if (!frame_end) begin
      col_count_next = '0;
      row_count_next = row_count + CW'(1);
    end else begin
      // drop the bounds and restart at the top of the next frame
      col_count_next = '0;
      row_count_next = '0;
      min_row_next   = '0;
      max_row_next   = '0;
      min_col_next   = MIN_COL_RST;
      max_col_next   = '0;
      any_found_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col_count <= '0;
      row_count <= '0;
      min_row   <= '0;
      max_row   <= '0;
      min_col   <= MIN_COL_RST;
      max_col   <= '0;
      any_found <= 1'b0;
    end else if (step) begin
      col_count <= col_count_next;
      row_count <= row_count_next;
      min_row   <= min_row_next;
      max_row   <= max_row_next;
      min_col   <= min_col_next;
      max_col   <= max_col_next;
      any_found <= any_found_next;
    end
  end

  // Result as it stands after the current pixel is folded in.
  always_comb begin
    status.frame_end = frame_end;
    if (any_found_upd && frame_end) begin
      status.box.top_row    = FIELD_W'(min_row_upd);
      status.box.bottom_end = FIELD_W'(CMPW'(max_row_upd) + CMPW'(1));
      status.box.left_col   = FIELD_W'(min_col_upd);
      status.box.right_end  = FIELD_W'(CMPW'(max_col_upd) + CMPW'(1));
    end else begin
      status.box.top_row    = '1;
      status.box.bottom_end = '0;
      status.box.left_col   = '1;
      status.box.right_end  = '0;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/object_bounding_box_core.sv =====
// Channel   Direction  Payload                                     Handshake
// pixel     in         pixel[7:0]                                  pixel_valid / pixel_stall
// box       out        top_row, bottom_end, left_col, right_end    box_valid / box_stall
// cfg       in         cfg_index[1:0], cfg_data[12:0]              cfg_we
//
// One pixel per cycle while box stall does not hold back a frame's last pixel:
// a pixel is held in the input register, then the bound compares fold it into
// the tracker state. A frame's last pixel passes the input register, and its box
// is loaded into the output register when that pixel is folded in.
// Synchronous active-high reset clears counters, bounds and valids; the
// size registers come up at 640 x 480 and the object color at 0.
// Box stall holds back only the last pixel of a frame while an older box
// still waits, and new pixels stall behind it; no other pixel waits on it.
`default_nettype none

`include "object_bounding_box_core_defines.svh"

module object_bounding_box_core
  import obb_pkg::*;
#(
  parameter int MAX_SIDE = OBB_MAX_SIDE
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  // configuration writes
  input  wire logic                        cfg_we,
  input  wire logic [CFG_IDX_W-1:0]        cfg_index,
  input  wire logic [FIELD_W-1:0]          cfg_data,
  // pixel stream
  input  wire logic                        pixel_valid,
  output logic                             pixel_stall,
  input  wire logic [PIX_W-1:0]            pixel,
  // bounding box results
  output logic                             box_valid,
  input  wire logic                        box_stall,
  output logic signed [FIELD_W-1:0]        top_row,
  output logic [FIELD_W-1:0]               bottom_end,
  output logic signed [FIELD_W-1:0]        left_col,
  output logic [FIELD_W-1:0]               right_end
);

  cfg_t          cfg;
  track_status_t status;

  // Input register
  logic             pix_valid;
  logic [PIX_W-1:0] pix_q;

  logic box_free;  // output register can take a new box this cycle
  logic proc;      // the held pixel is folded in this cycle
  logic emit;      // that pixel closes a frame, so a box is loaded

  obb_cfg #(
    .MAX_SIDE (MAX_SIDE)
  ) u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  obb_tracker #(
    .MAX_SIDE (MAX_SIDE)
  ) u_tracker (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg),
    .step   (proc),
    .pix    (pix_q),
    .status (status)
  );

  always_comb begin
    box_free    = !box_valid || !box_stall;
    // a pixel that does not end the frame never waits on the output side
    proc        = pix_valid && (!status.frame_end || box_free);
    emit        = proc && status.frame_end;
    // take a new pixel whenever the held one moves on or the register is empty
    pixel_stall = pix_valid && !proc;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pix_valid <= 1'b0;
    end else if (!pixel_stall) begin
      pix_valid <= pixel_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (pixel_valid && !pixel_stall) begin
      pix_q <= pixel;
    end
  end

  // Output register: load a finished box, drop it once the transaction completes
  always_ff @(posedge clk) begin
    if (rst) begin
      box_valid <= 1'b0;
    end else if (emit) begin
      box_valid <= 1'b1;
    end else if (!box_stall) begin
      box_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      top_row    <= status.box.top_row;
      bottom_end <= status.box.bottom_end;
      left_col   <= status.box.left_col;
      right_end  <= status.box.right_end;
    end
  end

  // An accepted pixel always lands in the input register.
  `OBB_ASSERT_NXT(a_pix_lands, clk, rst, pixel_valid && !pixel_stall, pix_valid)
  // A new box only appears after a frame-closing pixel was folded in.
  `OBB_ASSERT_IMP(a_box_from_frame_end, clk, rst, $rose(box_valid), $past(emit))
  // A found object has nonzero exclusive ends.
  `OBB_ASSERT_IMP(a_found_has_ends, clk, rst, box_valid && (top_row != '1),
                  (bottom_end != '0) && (right_end != '0))

endmodule

`default_nettype wire
